/* design/lsbcf_pkg.sv */
`default_nettype none
package lsbcf_pkg;

	localparam int MAX_HALF_WIDTH = 7;
	localparam int WIN_DEPTH = 2 * MAX_HALF_WIDTH + 1;
	localparam int IDX_W = $clog2(WIN_DEPTH);
	localparam int POS_W = $clog2(WIN_DEPTH + 1);
	localparam int HW_W = 3;
	localparam int GAIN_W = 17;
	localparam int CFG_W = 32;
	localparam int SUM_W = 36;
	localparam int WIDE_W = 54;
	localparam int DIV_STEPS = SUM_W;
	localparam int DCNT_W = $clog2(DIV_STEPS);

	localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'd65536;
	localparam logic [GAIN_W-1:0] RISE_RST = 17'd5339;
	localparam logic [GAIN_W-1:0] FALL_RST = 17'd5339;
	localparam logic [31:0] STIFF_RST = 32'd4112;
	localparam logic [31:0] DAMP_RST = 32'd1982;
	localparam logic [GAIN_W-1:0] DT_RST = 17'd1092;
	localparam logic [HW_W-1:0] HALF_RST = 3'd2;

	typedef enum logic [2:0] {
		REG_MODE, REG_RISE, REG_FALL, REG_STIFF, REG_DAMP, REG_DT, REG_HALF
	} cfg_reg_t;

	typedef enum logic [1:0] {MODE_LAG, MODE_SPRING, MODE_BOX, MODE_PASS} mode_t;
	typedef enum logic [1:0] {MUL_LAG, MUL_STIFF, MUL_DAMP, MUL_DT} mul_sel_t;
	typedef enum logic [1:0] {FIN_VALUE, FIN_NEG, FIN_VEL} fin_sel_t;
	typedef enum logic [1:0] {OUT_VALUE, OUT_BOX, OUT_SAMPLE} out_sel_t;

	typedef struct packed {
		logic signed [31:0] sample_in;
		logic               first_of_buffer;
		logic               last_of_buffer;
		logic               clear_state;
	} in_t;

	typedef struct packed {
		logic signed [31:0] sample_out;
		logic               end_of_buffer;
	} out_t;

	typedef struct packed {
		logic     load;
		logic     mul;
		mul_sel_t mul_sel;
		logic     rnd;
		logic     fin;
		fin_sel_t fin_sel;
		logic     box_dec;
		logic     sum_init;
		logic     sum_step;
		logic     div_init;
		logic     div_step;
		logic     emit;
		out_sel_t out_sel;
	} dp_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  last;
		logic  out_free;
		logic  age_lt_n;
		logic  age_zero;
		logic  sum_done;
		logic  div_done;
	} dp_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] x);
		logic signed [31:0] r;
		if (x > $signed(WIDE_W'(64'sd2147483647))) begin
			r = 32'sh7fffffff;
		end else if (x < -$signed(WIDE_W'(64'sd2147483648))) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	function automatic logic [GAIN_W-1:0] cap_unity(input logic [GAIN_W-1:0] g);
		return (g > UNITY_GAIN) ? UNITY_GAIN : g;
	endfunction

endpackage
`default_nettype wire

/* design/lsbcf_dp.sv */
`default_nettype none
module lsbcf_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [2:0]                   cfg_index,
	input  wire logic [lsbcf_pkg::CFG_W-1:0]  cfg_data,
	input  wire lsbcf_pkg::in_t               in_data,
	input  wire lsbcf_pkg::dp_cmd_t           cmd,
	output lsbcf_pkg::dp_stat_t               stat,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output lsbcf_pkg::out_t                   out_data
);

	// configuration
	lsbcf_pkg::mode_t                  mode_q;
	logic [lsbcf_pkg::GAIN_W-1:0]      rise_q, fall_q, dt_q;
	logic [31:0]                       stiff_q, damp_q;
	logic [lsbcf_pkg::HW_W-1:0]        half_q;

	// filter state
	logic signed [31:0]                value_q, vel_q, sample_q;
	logic                              seeded_q, last_q;
	logic signed [31:0]                win_q [lsbcf_pkg::WIN_DEPTH];
	logic [lsbcf_pkg::POS_W-1:0]       pos_q, n_q, pos_base, pos_new;
	logic [lsbcf_pkg::IDX_W-1:0]       age_q, k_q, lo, hi, hi0, n_m1;
	logic [lsbcf_pkg::POS_W-1:0]       cnt_q;

	// multiply unit
	logic signed [32:0]                mul_a;
	logic [31:0]                       mul_b;
	logic [32:0]                       mag;
	logic [64:0]                       prod_q;
	logic                              neg_q;
	logic [49:0]                       rmag;
	logic signed [lsbcf_pkg::WIDE_W-1:0] r_q, t_q;

	// box sum and divider
	logic signed [lsbcf_pkg::SUM_W-1:0] acc_q;
	logic [lsbcf_pkg::SUM_W-1:0]       num_q, acc_mag;
	logic [lsbcf_pkg::POS_W:0]         rem_q, rem2;
	logic                              dneg_q;
	logic [lsbcf_pkg::DCNT_W-1:0]      dcnt_q;
	logic signed [lsbcf_pkg::WIDE_W-1:0] qsig;
	logic signed [31:0]                box_val, out_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= lsbcf_pkg::MODE_LAG;
			rise_q  <= lsbcf_pkg::RISE_RST;
			fall_q  <= lsbcf_pkg::FALL_RST;
			stiff_q <= lsbcf_pkg::STIFF_RST;
			damp_q  <= lsbcf_pkg::DAMP_RST;
			dt_q    <= lsbcf_pkg::DT_RST;
			half_q  <= lsbcf_pkg::HALF_RST;
		end else if (cfg_we) begin
			case (lsbcf_pkg::cfg_reg_t'(cfg_index))
				lsbcf_pkg::REG_MODE:  mode_q <= lsbcf_pkg::mode_t'(cfg_data[1:0]);
				lsbcf_pkg::REG_RISE:  rise_q <= cfg_data[lsbcf_pkg::GAIN_W-1:0];
				lsbcf_pkg::REG_FALL:  fall_q <= cfg_data[lsbcf_pkg::GAIN_W-1:0];
				lsbcf_pkg::REG_STIFF: stiff_q <= cfg_data;
				lsbcf_pkg::REG_DAMP:  damp_q <= cfg_data;
				lsbcf_pkg::REG_DT:    dt_q <= cfg_data[lsbcf_pkg::GAIN_W-1:0];
				lsbcf_pkg::REG_HALF:  half_q <= cfg_data[lsbcf_pkg::HW_W-1:0];
				default: ;
			endcase
		end
	end

	// buffer position
	always_comb begin
		pos_base = in_data.first_of_buffer ? '0 : pos_q;
		pos_new  = (pos_base < lsbcf_pkg::POS_W'(lsbcf_pkg::WIN_DEPTH)) ?
			pos_base + 1'b1 : pos_base;
	end

	// window bounds for the current age
	always_comb begin
		lo   = (age_q >= lsbcf_pkg::IDX_W'(half_q)) ? age_q - lsbcf_pkg::IDX_W'(half_q) : '0;
		hi0  = age_q + lsbcf_pkg::IDX_W'(half_q);
		n_m1 = lsbcf_pkg::IDX_W'(n_q - 1'b1);
		hi   = (hi0 > n_m1) ? n_m1 : hi0;
	end

	// multiply operand select
	always_comb begin
		case (cmd.mul_sel)
			lsbcf_pkg::MUL_LAG: begin
				mul_a = 33'(sample_q) - 33'(value_q);
				mul_b = 32'(lsbcf_pkg::cap_unity((sample_q >= value_q) ? rise_q : fall_q));
			end
			lsbcf_pkg::MUL_STIFF: begin
				mul_a = 33'(value_q) - 33'(sample_q);
				mul_b = stiff_q;
			end
			lsbcf_pkg::MUL_DAMP: begin
				mul_a = 33'(vel_q);
				mul_b = damp_q;
			end
			default: begin
				mul_a = 33'(vel_q);
				mul_b = 32'(lsbcf_pkg::cap_unity(dt_q));
			end
		endcase
		mag  = mul_a[32] ? 33'(-mul_a) : 33'(mul_a);
		rmag = {1'b0, prod_q[64:16]} + 50'(prod_q[15]);
	end

	// divider step
	always_comb begin
		rem2    = {rem_q[lsbcf_pkg::POS_W-1:0], num_q[lsbcf_pkg::SUM_W-1]};
		acc_mag = acc_q[lsbcf_pkg::SUM_W-1] ? lsbcf_pkg::SUM_W'(-acc_q) : lsbcf_pkg::SUM_W'(acc_q);
		qsig    = dneg_q ? -$signed({18'd0, num_q}) : $signed({18'd0, num_q});
		box_val = lsbcf_pkg::sat32(qsig);
		case (cmd.out_sel)
			lsbcf_pkg::OUT_BOX:    out_val = box_val;
			lsbcf_pkg::OUT_SAMPLE: out_val = sample_q;
			default:               out_val = value_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q   <= '0;
			vel_q     <= '0;
			seeded_q  <= 1'b0;
			pos_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (in_data.clear_state || !seeded_q) begin
					value_q  <= in_data.sample_in;
					vel_q    <= '0;
					seeded_q <= 1'b1;
				end
				pos_q <= in_data.last_of_buffer ? '0 : pos_new;
			end
			if (cmd.fin) begin
				case (cmd.fin_sel)
					lsbcf_pkg::FIN_VEL: vel_q <= lsbcf_pkg::sat32(
						lsbcf_pkg::WIDE_W'(vel_q) + t_q - r_q);
					lsbcf_pkg::FIN_VALUE: value_q <= lsbcf_pkg::sat32(
						lsbcf_pkg::WIDE_W'(value_q) + r_q);
					default: ;
				endcase
			end
			if (cmd.emit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = lsbcf_pkg::WIN_DEPTH - 1; i > 0; i--) begin
				win_q[i] <= win_q[i-1];
			end
			win_q[0] <= in_data.sample_in;
			sample_q <= in_data.sample_in;
			last_q   <= in_data.last_of_buffer;
			n_q      <= pos_new;
			age_q    <= lsbcf_pkg::IDX_W'(half_q);
		end
		if (cmd.box_dec) begin
			age_q <= age_q - 1'b1;
		end
		if (cmd.mul) begin
			prod_q <= 65'(mag) * 65'(mul_b);
			neg_q  <= mul_a[32];
		end
		if (cmd.rnd) begin
			r_q <= neg_q ? -$signed({4'd0, rmag}) : $signed({4'd0, rmag});
		end
		if (cmd.fin && cmd.fin_sel == lsbcf_pkg::FIN_NEG) begin
			t_q <= -r_q;
		end
		if (cmd.sum_init) begin
			k_q   <= lo;
			acc_q <= '0;
			cnt_q <= lsbcf_pkg::POS_W'(hi - lo) + 1'b1;
		end
		if (cmd.sum_step) begin
			acc_q <= acc_q + lsbcf_pkg::SUM_W'(win_q[k_q]);
			k_q   <= k_q + 1'b1;
		end
		if (cmd.div_init) begin
			dneg_q <= acc_q[lsbcf_pkg::SUM_W-1];
			num_q  <= acc_mag + lsbcf_pkg::SUM_W'(cnt_q >> 1);
			rem_q  <= '0;
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			if (rem2 >= {1'b0, cnt_q}) begin
				rem_q <= rem2 - {1'b0, cnt_q};
				num_q <= {num_q[lsbcf_pkg::SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem2;
				num_q <= {num_q[lsbcf_pkg::SUM_W-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (cmd.emit) begin
			out_data.sample_out    <= out_val;
			out_data.end_of_buffer <= (cmd.out_sel == lsbcf_pkg::OUT_BOX) ?
				(last_q && age_q == '0) : last_q;
		end
	end

	always_comb begin
		stat.mode     = mode_q;
		stat.last     = last_q;
		stat.out_free = !out_valid || !out_stall;
		stat.age_lt_n = lsbcf_pkg::POS_W'(age_q) < n_q;
		stat.age_zero = age_q == '0;
		stat.sum_done = k_q == hi;
		stat.div_done = dcnt_q == lsbcf_pkg::DCNT_W'(lsbcf_pkg::DIV_STEPS - 1);
	end

endmodule
`default_nettype wire

/* design/lsbcf_ctrl.sv */
`default_nettype none
module lsbcf_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire lsbcf_pkg::dp_stat_t stat,
	output lsbcf_pkg::dp_cmd_t       cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_RND, ST_FIN, ST_PICK, ST_SUM, ST_DIVI, ST_DIV, ST_EMIT
	} state_t;

	state_t     state_q;
	logic [1:0] step_q;
	logic       spring;
	logic       box_more;

	assign in_stall = state_q != ST_IDLE;
	assign spring   = stat.mode == lsbcf_pkg::MODE_SPRING;
	assign box_more = stat.last && !stat.age_zero;

	always_comb begin
		cmd = '0;
		case (step_q)
			2'd0:    cmd.mul_sel = spring ? lsbcf_pkg::MUL_STIFF : lsbcf_pkg::MUL_LAG;
			2'd1:    cmd.mul_sel = lsbcf_pkg::MUL_DAMP;
			default: cmd.mul_sel = lsbcf_pkg::MUL_DT;
		endcase
		case (step_q)
			2'd0:    cmd.fin_sel = spring ? lsbcf_pkg::FIN_NEG : lsbcf_pkg::FIN_VALUE;
			2'd1:    cmd.fin_sel = lsbcf_pkg::FIN_VEL;
			default: cmd.fin_sel = lsbcf_pkg::FIN_VALUE;
		endcase
		case (stat.mode)
			lsbcf_pkg::MODE_BOX:  cmd.out_sel = lsbcf_pkg::OUT_BOX;
			lsbcf_pkg::MODE_PASS: cmd.out_sel = lsbcf_pkg::OUT_SAMPLE;
			default:              cmd.out_sel = lsbcf_pkg::OUT_VALUE;
		endcase
		case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_MUL:  cmd.mul = 1'b1;
			ST_RND:  cmd.rnd = 1'b1;
			ST_FIN:  cmd.fin = 1'b1;
			ST_PICK: begin
				cmd.sum_init = stat.age_lt_n;
				cmd.box_dec  = !stat.age_lt_n && box_more;
			end
			ST_SUM:  cmd.sum_step = 1'b1;
			ST_DIVI: cmd.div_init = 1'b1;
			ST_DIV:  cmd.div_step = 1'b1;
			ST_EMIT: begin
				cmd.emit    = stat.out_free;
				cmd.box_dec = stat.out_free && stat.mode == lsbcf_pkg::MODE_BOX && box_more;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (in_valid) begin
						case (stat.mode)
							lsbcf_pkg::MODE_BOX:  state_q <= ST_PICK;
							lsbcf_pkg::MODE_PASS: state_q <= ST_EMIT;
							default:              state_q <= ST_MUL;
						endcase
					end
				end
				ST_MUL: state_q <= ST_RND;
				ST_RND: state_q <= ST_FIN;
				ST_FIN: begin
					if (spring && step_q != 2'd2) begin
						step_q  <= step_q + 1'b1;
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_PICK: begin
					if (stat.age_lt_n) begin
						state_q <= ST_SUM;
					end else if (!box_more) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SUM: begin
					if (stat.sum_done) begin
						state_q <= ST_DIVI;
					end
				end
				ST_DIVI: state_q <= ST_DIV;
				ST_DIV: begin
					if (stat.div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (stat.out_free) begin
						if (stat.mode == lsbcf_pkg::MODE_BOX && box_more) begin
							state_q <= ST_PICK;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* design/lag_spring_box_channel_filter_core.sv */
// Per accepted beat: pass goes straight to the output register, lag runs the
// multiply/round/finish pass, spring runs it for stiffness, damping and time step.
// Box: each result sums its window taps and divides; ages past the taps are skipped.
// One sample in flight; the next beat is taken once its last result sits in the output reg.
// Reset: config registers return to defaults, filter state and buffer position
// clear; the window taps are not cleared (only taps of the current buffer are read).
`default_nettype none
module lag_spring_box_channel_filter_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration write port
	input  wire logic                        cfg_we,
	input  wire logic [2:0]                  cfg_index,
	input  wire logic [lsbcf_pkg::CFG_W-1:0] cfg_data,
	// sample input channel
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire lsbcf_pkg::in_t              in_data,
	// result channel
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output lsbcf_pkg::out_t                  out_data
);

	// command/status bus between sequencer and datapath
	lsbcf_pkg::dp_cmd_t  cmd;
	lsbcf_pkg::dp_stat_t stat;

	// sequencer: seeds and loads on an accepted beat, then walks the multiply/round/finish
	// steps, the box sum/divide loop per result, or goes straight to emit in pass mode
	lsbcf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: config, window taps, shared multiplier, divider, output register
	lsbcf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
